FILE: design/okvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_pkg
// Shared types and command codes for the ordered key/value list unit.
// ----------------------------------------------------------------------------
package okvl_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_KEY   = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_DUMP      = 3'd5;

  // One command beat.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic               ok;
    logic               has_entry;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_value;
    logic               last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic find;
    logic apply;
    logic dump_start;
    logic dump_step;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dump;
    logic dump_final;
    logic rsp_free;
  } stat_t;

endpackage

FILE: design/okvl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_datapath
// Chain of key/value cells with parallel key compare, entry count, command
// register and the registered result stage.
// ----------------------------------------------------------------------------
module okvl_datapath #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  okvl_pkg::cmd_t  cmd,
  input  okvl_pkg::ctl_t  ctl,
  output okvl_pkg::stat_t stat,
  output okvl_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_ready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  okvl_pkg::cmd_t     cur;
  logic signed [31:0] keys [DEPTH];
  logic signed [31:0] vals [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      dump_left;
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   span_next;
  logic [DEPTH-1:0]   hit_span;
  logic [DEPTH-1:0]   drop_mask;
  logic               full;
  logic               empty;
  logic               apply_ok;
  logic               rsp_free;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign rsp_free = !rsp_valid || rsp_ready;

  // Every live cell compares its key with the search key at once.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (keys[i] == cur.key) && (CW'(i) < count);
    end
  end

  // Prefix OR in log steps: bit i is set from the first match upwards.
  always_comb begin
    span_next = match;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      span_next = span_next | (span_next << s);
    end
  end

  // Outcome of the held command against the current list.
  always_comb begin
    unique case (cur.op)
      okvl_pkg::OP_INS_FRONT, okvl_pkg::OP_INS_BACK: apply_ok = !full;
      okvl_pkg::OP_REM_KEY:                           apply_ok = hit_span[DEPTH-1];
      okvl_pkg::OP_REM_FRONT, okvl_pkg::OP_CLEAR:     apply_ok = !empty;
      default:                                        apply_ok = 1'b0;
    endcase
  end

  // Removing the front closes the gap from cell zero; a key removal from the match.
  assign drop_mask = (cur.op == okvl_pkg::OP_REM_FRONT) ? '1 : hit_span;

  assign stat.is_dump    = (cur.op == okvl_pkg::OP_DUMP) && !empty;
  assign stat.dump_final = (dump_left == ONE);
  assign stat.rsp_free   = rsp_free;

  // Command register and registered match span.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur <= cmd;
    end
    if (ctl.find) begin
      hit_span <= span_next;
    end
  end

  // Cell chain: shift up, shift down from a point, write at the tail, or rotate.
  always_ff @(posedge clk) begin
    if (ctl.apply && apply_ok) begin
      unique case (cur.op)
        okvl_pkg::OP_INS_FRONT: begin
          keys[0] <= cur.key;
          vals[0] <= cur.value;
          for (int i = 1; i < DEPTH; i++) begin
            keys[i] <= keys[i-1];
            vals[i] <= vals[i-1];
          end
        end
        okvl_pkg::OP_INS_BACK: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) == count) begin
              keys[i] <= cur.key;
              vals[i] <= cur.value;
            end
          end
        end
        okvl_pkg::OP_REM_KEY, okvl_pkg::OP_REM_FRONT: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (drop_mask[i]) begin
              keys[i] <= keys[i+1];
              vals[i] <= vals[i+1];
            end
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.dump_step) begin
      // Rotate the live part by one so the next entry reaches cell zero.
      for (int i = 0; i < DEPTH - 1; i++) begin
        keys[i] <= keys[i+1];
        vals[i] <= vals[i+1];
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) == count - ONE) begin
          keys[i] <= keys[0];
          vals[i] <= vals[0];
        end
      end
    end
  end

  // Entry count and dump counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_left <= '0;
    end else begin
      if (ctl.apply && apply_ok) begin
        unique case (cur.op)
          okvl_pkg::OP_INS_FRONT, okvl_pkg::OP_INS_BACK: count <= count + ONE;
          okvl_pkg::OP_REM_KEY, okvl_pkg::OP_REM_FRONT:  count <= count - ONE;
          okvl_pkg::OP_CLEAR:                            count <= '0;
          default: begin
          end
        endcase
      end
      if (ctl.dump_start) begin
        dump_left <= count;
      end else if (ctl.dump_step) begin
        dump_left <= dump_left - ONE;
      end
    end
  end

  // Result register: holds a beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.apply || ctl.dump_step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      rsp.ok          <= apply_ok;
      rsp.has_entry   <= 1'b0;
      rsp.entry_key   <= '0;
      rsp.entry_value <= '0;
      rsp.last        <= 1'b1;
    end else if (ctl.dump_step) begin
      rsp.ok          <= 1'b1;
      rsp.has_entry   <= 1'b1;
      rsp.entry_key   <= keys[0];
      rsp.entry_value <= vals[0];
      rsp.last        <= (dump_left == ONE);
    end
  end

endmodule

FILE: design/okvl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_ctrl
// Command sequencer: take, search, apply or walk the list for a dump.
// ----------------------------------------------------------------------------
module okvl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  okvl_pkg::stat_t stat,
  output okvl_pkg::ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_DUMP
  } state_t;

  state_t state;

  assign cmd_ready = (state == S_IDLE);

  // Command decode from the current state and datapath status.
  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE:  ctl.take = cmd_valid;
      S_FIND:  ctl.find = 1'b1;
      S_APPLY: begin
        if (stat.rsp_free) begin
          ctl.dump_start = stat.is_dump;
          ctl.apply      = !stat.is_dump;
        end
      end
      S_DUMP:  ctl.dump_step = stat.rsp_free;
      default: ctl = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) state <= S_FIND;
        end
        S_FIND: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (stat.rsp_free) state <= stat.is_dump ? S_DUMP : S_IDLE;
        end
        S_DUMP: begin
          if (stat.rsp_free && stat.dump_final) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ordered_key_value_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_list_unit
// Ordered list of up to DEPTH key/value pairs driven by one command per beat.
//
//   Channel  Signals                        Role
//   cmd      cmd_valid, cmd_ready, cmd      one command beat (op, key, value)
//   rsp      rsp_valid, rsp_ready, rsp      one result beat, last marks the end
//
// A command runs through capture, parallel key search in the cell chain, then
// apply with its result loaded into the output register. A dump of a non-empty
// list emits its entries in turn, front first, as the chain rotates.
// Back-pressure on rsp holds the apply or dump step until the output register
// is free. Reset empties the list by clearing the entry count; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_key_value_list_unit #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  okvl_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output okvl_pkg::rsp_t rsp
);

  okvl_pkg::ctl_t  ctl;
  okvl_pkg::stat_t stat;

  // Sequencer.
  okvl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Cells, count and result register.
  okvl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

FILE: sim/ordered_key_value_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_list_unit_test
// Self-checking bench for the ordered key/value list unit. A mirror of the
// list, kept in a small scoreboard, predicts every result beat of each
// accepted command. A directed opening covers the corner cases, and random
// fill, drain and mixed phases follow. The command side sends in bursts and
// the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module ordered_key_value_list_unit_test;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_BEATS = 110;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;

  // Op codes that the unit does not define.
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  localparam logic [2:0] LIST_OPS [6] = '{okvl_pkg::OP_INS_FRONT, okvl_pkg::OP_INS_BACK,
                                          okvl_pkg::OP_REM_KEY, okvl_pkg::OP_REM_FRONT,
                                          okvl_pkg::OP_CLEAR, okvl_pkg::OP_DUMP};

  typedef enum int {MIX_FILL, MIX_ANY, MIX_DRAIN} mix_t;

  // Mirror of the list contents and the results still owed by the unit.
  class list_book;
    logic signed [31:0] keys [LIST_DEPTH];
    logic signed [31:0] values [LIST_DEPTH];
    int                 fill;
    okvl_pkg::rsp_t     due [$];
    int                 mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Close the gap left by the entry at the given position.
    function void close_gap(int at);
      int pos;
      for (pos = at; pos + 1 < fill; pos++) begin
        keys[pos] = keys[pos + 1];
        values[pos] = values[pos + 1];
      end
      fill--;
    endfunction

    // Apply one accepted command beat and queue the result beats it causes.
    function void take_command(okvl_pkg::cmd_t c);
      okvl_pkg::rsp_t r;
      logic ok;
      int   pos;
      int   hit;
      ok = 1'b0;
      hit = -1;
      case (c.op)
        okvl_pkg::OP_INS_FRONT: begin
          if (fill < LIST_DEPTH) begin
            for (pos = fill; pos > 0; pos--) begin
              keys[pos] = keys[pos - 1];
              values[pos] = values[pos - 1];
            end
            keys[0] = c.key;
            values[0] = c.value;
            fill++;
            ok = 1'b1;
          end
        end
        okvl_pkg::OP_INS_BACK: begin
          if (fill < LIST_DEPTH) begin
            keys[fill] = c.key;
            values[fill] = c.value;
            fill++;
            ok = 1'b1;
          end
        end
        okvl_pkg::OP_REM_KEY: begin
          for (pos = 0; pos < fill; pos++) begin
            if (hit < 0 && keys[pos] == c.key) hit = pos;
          end
          if (hit >= 0) begin
            close_gap(hit);
            ok = 1'b1;
          end
        end
        okvl_pkg::OP_REM_FRONT: begin
          if (fill > 0) begin
            close_gap(0);
            ok = 1'b1;
          end
        end
        okvl_pkg::OP_CLEAR: begin
          if (fill > 0) begin
            fill = 0;
            ok = 1'b1;
          end
        end
        okvl_pkg::OP_DUMP: begin
          // A non-empty list is emitted front to back, one beat per entry.
          if (fill > 0) begin
            for (pos = 0; pos < fill; pos++) begin
              r = '0;
              r.ok = 1'b1;
              r.has_entry = 1'b1;
              r.entry_key = keys[pos];
              r.entry_value = values[pos];
              r.last = (pos == fill - 1);
              due.push_back(r);
            end
            return;
          end
        end
        default: begin
        end
      endcase
      r = '0;
      r.ok = ok;
      r.last = 1'b1;
      due.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest one owed.
    function void check_result(okvl_pkg::rsp_t got);
      okvl_pkg::rsp_t want;
      if (due.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.has_entry !== want.has_entry) begin
        $error("has_entry: expected %0d, actual %0d", want.has_entry, got.has_entry);
        mismatches++;
      end
      if (got.entry_key !== want.entry_key) begin
        $error("entry_key: expected %0d, actual %0d", want.entry_key, got.entry_key);
        mismatches++;
      end
      if (got.entry_value !== want.entry_value) begin
        $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_ready;
  okvl_pkg::cmd_t cmd       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  okvl_pkg::rsp_t rsp;

  list_book           book = new();
  logic signed [31:0] key_pool [8];
  int                 burst_left = 0;
  int                 rx_run = 0;
  int                 quiet_cycles = 0;

  ordered_key_value_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: alternating runs of readiness and stalls, now and then a long
  // run with no stall at all.
  always @(posedge clk) begin
    if (rx_run > 0) begin
      rx_run <= rx_run - 1;
    end else if (rsp_ready) begin
      rsp_ready <= 1'b0;
      rx_run <= $urandom_range(0, 11);
    end else begin
      rsp_ready <= 1'b1;
      rx_run <= ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(0, 15);
    end
  end

  // Beat monitor and watchdog on cycles without progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) book.take_command(cmd);
      if (rsp_valid && rsp_ready) book.check_result(rsp);
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ordered_key_value_list_unit verification failed");
        $finish;
      end
    end
  end

  // Present one command beat and hold it until the unit takes it. Beats go
  // out in bursts, mostly with idle gaps between them.
  task automatic send_cmd(okvl_pkg::cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // Keys mostly come from a small pool so that removals find matches and
  // duplicates occur.
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic okvl_pkg::cmd_t pick_command(mix_t mix);
    okvl_pkg::cmd_t c;
    int             roll;
    c.key = pick_key();
    c.value = $urandom();
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 45) c.op = okvl_pkg::OP_INS_FRONT;
        else if (roll < 90) c.op = okvl_pkg::OP_INS_BACK;
        else if (roll < 96) c.op = okvl_pkg::OP_DUMP;
        else c.op = okvl_pkg::OP_REM_KEY;
      end
      MIX_DRAIN: begin
        if (roll < 35) c.op = okvl_pkg::OP_REM_KEY;
        else if (roll < 70) c.op = okvl_pkg::OP_REM_FRONT;
        else if (roll < 85) c.op = okvl_pkg::OP_DUMP;
        else if (roll < 90) c.op = okvl_pkg::OP_CLEAR;
        else if (roll < 95) c.op = okvl_pkg::OP_INS_BACK;
        else c.op = okvl_pkg::OP_INS_FRONT;
      end
      default: begin
        if (roll < 94) c.op = LIST_OPS[$urandom_range(0, 5)];
        else if (roll < 97) c.op = OP_BAD_LO;
        else c.op = OP_BAD_HI;
      end
    endcase
    return c;
  endfunction

  // Main sequence: reset, directed corner cases, then random phases.
  initial begin
    int   sent;
    int   seg;
    int   n;
    mix_t mix;
    key_pool[0] = 32'h80000000;
    key_pool[1] = 32'h7FFFFFFF;
    key_pool[2] = 32'hFFFFFFFF;
    key_pool[3] = 32'h00000000;
    for (n = 4; n < 8; n++) key_pool[n] = $urandom();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The removals, the clear and the dump on an empty list, and the undefined op codes.
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_CLEAR, 32'h00000000, 32'hFFFFFFFF});
    send_cmd('{okvl_pkg::OP_REM_FRONT, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_REM_KEY, 32'h7FFFFFFF, 32'h00000000});
    send_cmd('{OP_BAD_LO, 32'h0F0F0F0F, 32'hF0F0F0F0});
    send_cmd('{OP_BAD_HI, 32'hF0F0F0F0, 32'h0F0F0F0F});

    // Extreme keys and values, a duplicate key, then removals and a clear.
    send_cmd('{okvl_pkg::OP_INS_FRONT, 32'h80000000, 32'h7FFFFFFF});
    send_cmd('{okvl_pkg::OP_INS_BACK, 32'h7FFFFFFF, 32'h80000000});
    send_cmd('{okvl_pkg::OP_INS_FRONT, 32'hFFFFFFFF, 32'h00000000});
    send_cmd('{okvl_pkg::OP_INS_BACK, 32'h00000000, 32'hFFFFFFFF});
    send_cmd('{okvl_pkg::OP_INS_BACK, 32'hFFFFFFFF, 32'h00000005});
    send_cmd('{OP_BAD_HI, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_REM_KEY, 32'h00003039, 32'h00000000});
    send_cmd('{okvl_pkg::OP_REM_KEY, 32'hFFFFFFFF, 32'h12345678});
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_REM_FRONT, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_CLEAR, 32'h00000000, 32'h00000000});
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});

    // Fill past capacity so that inserts are refused, then read it all out.
    for (n = 0; n < LIST_DEPTH + 2; n++) begin
      send_cmd('{(n % 2) ? okvl_pkg::OP_INS_BACK : okvl_pkg::OP_INS_FRONT,
                 pick_key(), $urandom()});
    end
    send_cmd('{okvl_pkg::OP_DUMP, 32'h00000000, 32'h00000000});
    sent = 20 + LIST_DEPTH + 3;

    // Random phases that grow, shrink or churn the list.
    while (sent < RANDOM_BEATS) begin
      mix = mix_t'($urandom_range(0, 2));
      seg = $urandom_range(8, 24);
      if (seg > RANDOM_BEATS - sent) seg = RANDOM_BEATS - sent;
      repeat (seg) send_cmd(pick_command(mix));
      sent += seg;
    end
    cmd_valid <= 1'b0;

    // Drain every owed result, then watch a little longer for stray beats.
    @(posedge clk);
    while (book.due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("ordered_key_value_list_unit verification clean");
    end else begin
      $display("ordered_key_value_list_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/okvl_pkg.sv
design/okvl_datapath.sv
design/okvl_ctrl.sv
design/ordered_key_value_list_unit.sv
sim/ordered_key_value_list_unit_test.sv
